### design/ipv4_header_parser_assert.svh
// assertion macros for the ipv4 header parser
`ifndef IPV4_HEADER_PARSER_ASSERT_SVH
`define IPV4_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH
`define IHP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define IHP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IHP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define IHP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### design/ihp_pkg.sv
// types and constants shared by the ipv4 header parser
package ihp_pkg;

	localparam logic [15:0] HDR_LEN      = 16'd20;
	localparam logic [15:0] IDX_LAST_HDR = 16'd19;
	localparam logic [15:0] IDX_FIRST    = 16'd0;
	localparam logic [15:0] IDX_TLEN     = 16'd3;
	localparam logic [15:0] IDX_IDENT    = 16'd5;
	localparam logic [15:0] IDX_FRAG     = 16'd7;
	localparam logic [15:0] IDX_TTL      = 16'd8;
	localparam logic [15:0] IDX_PROTO    = 16'd9;
	localparam logic [15:0] IDX_CSUM     = 16'd11;
	localparam logic [15:0] IDX_SRC_LO   = 16'd12;
	localparam logic [15:0] IDX_SRC_HI   = 16'd15;
	localparam logic [3:0]  VERSION_V4   = 4'h4;
	localparam logic [3:0]  IHL_NO_OPTS  = 4'h5;

	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_PAYLOAD,
		KIND_LAST,
		KIND_REJECT
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_NOT_V4,
		ST_OPTIONS,
		ST_LEN_OVER,
		ST_LEN_UNDER
	} status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [15:0] buffer_length;
	} beat_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [15:0] ident;
		logic [2:0]  flag_bits;
		logic [12:0] fragment_offset;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [15:0] received_checksum;
		logic [15:0] computed_checksum;
		logic [7:0]  payload_byte;
	} result_t;

endpackage

### design/ihp_in_if.sv
// byte stream channel into the parser
interface ihp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic [15:0] buffer_length;

	modport source (output valid, data_byte, first_byte, buffer_length, input ready);
	modport sink (input valid, data_byte, first_byte, buffer_length, output ready);
endinterface

### design/ihp_out_if.sv
// result channel out of the parser
interface ihp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  status;
	logic [15:0] ident;
	logic [2:0]  flag_bits;
	logic [12:0] fragment_offset;
	logic [7:0]  time_to_live;
	logic [7:0]  protocol;
	logic [31:0] source_addr;
	logic [31:0] dest_addr;
	logic [15:0] received_checksum;
	logic [15:0] computed_checksum;
	logic [7:0]  payload_byte;

	modport source (output valid, kind, status, ident, flag_bits, fragment_offset,
		time_to_live, protocol, source_addr, dest_addr, received_checksum,
		computed_checksum, payload_byte, input ready);
	modport sink (input valid, kind, status, ident, flag_bits, fragment_offset,
		time_to_live, protocol, source_addr, dest_addr, received_checksum,
		computed_checksum, payload_byte, output ready);
endinterface

### design/ipv4_header_parser.sv
// Streaming IPv4 header parser with header checksum.
// rx carries one buffer byte per beat with a first-byte mark and the buffer
// length; tx carries at most one result per byte: the header (after byte 19),
// a payload byte, the last payload byte, or a reject with its reason.
// A first-byte beat restarts parsing at byte 0 even in the middle of a buffer.
// A byte accepted on rx passes through an input register and a result register
// before its result, if any, appears on tx.
// Throughput: one byte per cycle while tx does not stall, set by the single 16-bit
// end-around-carry add of the checksum and the byte counter compare between the two registers.
// Bytes that give no result (header bytes 0 to 18 that are not rejected,
// dropped bytes) leave tx untouched.
// When tx stalls, the result register holds and rx keeps accepting until the
// input register also fills; rx.ready then falls in the same cycle.
// Reset empties both registers and puts the parser in the dropping state,
// so bytes before the first start mark are ignored.
`include "ipv4_header_parser_assert.svh"

module ipv4_header_parser
	import ihp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ihp_in_if.sink    rx,
	ihp_out_if.source tx
);

	logic    valid_s1;
	beat_t   beat_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    adv;
	logic    res_valid;
	result_t res;

	assign adv      = valid_s1 && (!valid_s2 || tx.ready);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			beat_s1 <= '{data_byte: rx.data_byte, first_byte: rx.first_byte,
				buffer_length: rx.buffer_length};
		end
	end

	ihp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.beat      (beat_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid;
		end else if (tx.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign tx.valid             = valid_s2;
	assign tx.kind              = res_s2.kind;
	assign tx.status            = res_s2.status;
	assign tx.ident             = res_s2.ident;
	assign tx.flag_bits         = res_s2.flag_bits;
	assign tx.fragment_offset   = res_s2.fragment_offset;
	assign tx.time_to_live      = res_s2.time_to_live;
	assign tx.protocol          = res_s2.protocol;
	assign tx.source_addr       = res_s2.source_addr;
	assign tx.dest_addr         = res_s2.dest_addr;
	assign tx.received_checksum = res_s2.received_checksum;
	assign tx.computed_checksum = res_s2.computed_checksum;
	assign tx.payload_byte      = res_s2.payload_byte;

	`IHP_ASSERT_IMP(a_ready_only_full, clk, arst_n, !rx.ready,
		valid_s1 && valid_s2 && !tx.ready, "rx stalled while a register is free")
	`IHP_ASSERT_NXT(a_s1_kept, clk, arst_n, valid_s1 && valid_s2 && !tx.ready,
		valid_s1, "input beat lost during output stall")
	`IHP_ASSERT_IMP(a_non_reject_ok, clk, arst_n,
		tx.valid && res_s2.kind != KIND_REJECT, res_s2.status == ST_OK,
		"non-reject result with a reject status")
	`IHP_ASSERT_IMP(a_reject_reason, clk, arst_n,
		tx.valid && res_s2.kind == KIND_REJECT, res_s2.status != ST_OK,
		"reject result without a reason")

endmodule

### design/ihp_parse.sv
// per-byte parse state and result logic
module ihp_parse
	import ihp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  beat_t   beat,
	output logic    res_valid,
	output result_t res
);

	logic [15:0] idx_q, idx, idx_n;
	logic [15:0] sum_q, sum, sum_n;
	logic        drop_q, drop, drop_n;
	logic [7:0]  hold_q, hold_n;
	logic [15:0] tlen_q, tlen_n;
	logic [15:0] ident_q, ident_n;
	logic [15:0] frag_q, frag_n;
	logic [7:0]  ttl_q, ttl_n;
	logic [7:0]  proto_q, proto_n;
	logic [31:0] src_q, src_n;
	logic [31:0] dst_q, dst_n;
	logic [15:0] csum_q, csum_n;
	logic [15:0] word;
	logic [16:0] sum_x;
	logic [15:0] sum_add;
	logic        rej;
	status_t     rej_code;

	always_comb begin
		// a start beat begins afresh at byte 0 whatever came before
		idx  = beat.first_byte ? '0 : idx_q;
		sum  = beat.first_byte ? '0 : sum_q;
		drop = beat.first_byte ? 1'b0 : drop_q;

		word    = {hold_q, beat.data_byte};
		sum_x   = {1'b0, sum} + {1'b0, word};
		sum_add = sum_x[15:0] + {15'd0, sum_x[16]};

		idx_n   = idx;
		sum_n   = sum;
		drop_n  = drop;
		hold_n  = hold_q;
		tlen_n  = tlen_q;
		ident_n = ident_q;
		frag_n  = frag_q;
		ttl_n   = ttl_q;
		proto_n = proto_q;
		src_n   = src_q;
		dst_n   = dst_q;
		csum_n  = csum_q;
		rej      = 1'b0;
		rej_code = ST_OK;
		res       = '0;
		res_valid = 1'b0;

		if (!drop) begin
			if (idx < HDR_LEN) begin
				if (idx == IDX_FIRST) begin
					if (beat.buffer_length < HDR_LEN) begin
						rej = 1'b1;
						rej_code = ST_SHORT;
					end else if (beat.data_byte[7:4] != VERSION_V4) begin
						rej = 1'b1;
						rej_code = ST_NOT_V4;
					end else if (beat.data_byte[3:0] != IHL_NO_OPTS) begin
						rej = 1'b1;
						rej_code = ST_OPTIONS;
					end
				end
				if (!idx[0]) begin
					hold_n = beat.data_byte;
				end else if (idx != IDX_CSUM) begin
					sum_n = sum_add;
				end
				if (idx == IDX_TLEN) begin
					tlen_n = word;
					if (word > beat.buffer_length) begin
						rej = 1'b1;
						rej_code = ST_LEN_OVER;
					end else if (word < HDR_LEN) begin
						rej = 1'b1;
						rej_code = ST_LEN_UNDER;
					end
				end else if (idx == IDX_IDENT) begin
					ident_n = word;
				end else if (idx == IDX_FRAG) begin
					frag_n = word;
				end else if (idx == IDX_TTL) begin
					ttl_n = beat.data_byte;
				end else if (idx == IDX_PROTO) begin
					proto_n = beat.data_byte;
				end else if (idx == IDX_CSUM) begin
					csum_n = word;
				end else if (idx >= IDX_SRC_LO && idx <= IDX_SRC_HI) begin
					src_n = {src_q[23:0], beat.data_byte};
				end else if (idx > IDX_SRC_HI) begin
					dst_n = {dst_q[23:0], beat.data_byte};
				end

				if (rej) begin
					res_valid  = 1'b1;
					res.kind   = KIND_REJECT;
					res.status = rej_code;
					drop_n     = 1'b1;
				end else if (idx != IDX_LAST_HDR) begin
					idx_n = idx + 16'd1;
				end else begin
					res_valid             = 1'b1;
					res.kind              = KIND_HEADER;
					res.ident             = ident_n;
					res.flag_bits         = frag_n[15:13];
					res.fragment_offset   = frag_n[12:0];
					res.time_to_live      = ttl_n;
					res.protocol          = proto_n;
					res.source_addr       = src_n;
					res.dest_addr         = dst_n;
					res.received_checksum = csum_n;
					res.computed_checksum = ~sum_n;
					if (tlen_q <= HDR_LEN) begin
						drop_n = 1'b1;
					end else begin
						idx_n = HDR_LEN;
					end
				end
			end else if (idx >= tlen_q) begin
				// trailing bytes past the total length
				drop_n = 1'b1;
			end else begin
				res_valid        = 1'b1;
				res.payload_byte = beat.data_byte;
				if (idx + 16'd1 == tlen_q) begin
					res.kind = KIND_LAST;
					drop_n   = 1'b1;
				end else begin
					res.kind = KIND_PAYLOAD;
					idx_n    = idx + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			sum_q  <= '0;
			drop_q <= 1'b1;
		end else if (fire) begin
			idx_q  <= idx_n;
			sum_q  <= sum_n;
			drop_q <= drop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hold_q  <= hold_n;
			tlen_q  <= tlen_n;
			ident_q <= ident_n;
			frag_q  <= frag_n;
			ttl_q   <= ttl_n;
			proto_q <= proto_n;
			src_q   <= src_n;
			dst_q   <= dst_n;
			csum_q  <= csum_n;
		end
	end

endmodule
